FILE: src/itm_pkg.sv
// Shared types, codes and constants for the ISDN user-side TEI manager.
// No dependencies; imported by every module of the block.
`default_nettype none

package itm_pkg;

    localparam int unsigned TEI_W     = 7;
    localparam int unsigned REF_W     = 16;
    localparam int unsigned TIMER_W   = 16;
    localparam int unsigned ATTEMPT_W = 4;

    localparam logic [TEI_W-1:0]     TEI_BROADCAST = 7'd127;
    localparam logic [7:0]           MGMT_ENTITY   = 8'h0f;
    localparam logic [7:0]           CTRL_UI       = 8'h03;
    localparam logic [7:0]           CTRL_POLL_MSK = 8'hef;
    localparam logic [TIMER_W-1:0]   RETRY_RESET   = 16'd200;
    localparam logic [ATTEMPT_W-1:0] ATTEMPT_RESET = 4'd3;

    localparam int unsigned S_TDATA_W = 72;
    localparam int unsigned M_TDATA_W = 40;

    typedef enum logic [1:0] {
        FUNC_START  = 2'd0,
        FUNC_TICK   = 2'd1,
        FUNC_FRAME  = 2'd2,
        FUNC_STATIC = 2'd3
    } func_t;

    typedef enum logic [7:0] {
        MT_REQUEST   = 8'd1,
        MT_ASSIGNED  = 8'd2,
        MT_DENIED    = 8'd3,
        MT_CHECK_REQ = 8'd4,
        MT_CHECK_RSP = 8'd5,
        MT_REMOVE    = 8'd6
    } msg_type_t;

    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_REQUEST  = 3'd1,
        EV_CHECK    = 3'd2,
        EV_ERROR    = 3'd3,
        EV_ASSIGNED = 3'd4,
        EV_REMOVED  = 3'd5,
        EV_REJECTED = 3'd6
    } event_t;

    typedef enum logic [0:0] {
        CFG_RETRY_TIMEOUT = 1'b0,
        CFG_MAX_ATTEMPTS  = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [TIMER_W-1:0]   retry_timeout_ticks;
        logic [ATTEMPT_W-1:0] max_request_attempts;
    } itm_cfg_t;

    typedef struct packed {
        logic                 assigned_flag;
        logic                 request_pending;
        logic [REF_W-1:0]     pending_ref;
        logic [TEI_W-1:0]     own_tei;
        logic [ATTEMPT_W-1:0] attempt_count;
        logic [TIMER_W-1:0]   timer_left;
        logic                 timer_armed;
    } itm_state_t;

    typedef struct packed {
        logic [1:0]       func;
        logic [REF_W-1:0] random_ref;
        logic             frame_long_enough;
        logic [7:0]       control_byte;
        logic [7:0]       entity_id;
        logic [7:0]       msg_code;
        logic [REF_W-1:0] frame_ref;
        logic [TEI_W-1:0] frame_action_tei;
        logic [TEI_W-1:0] static_tei;
    } itm_item_t;

    typedef struct packed {
        logic [2:0]       event_res;
        logic [2:0]       send_msg_type;
        logic [REF_W-1:0] send_ref;
        logic [TEI_W-1:0] send_action_tei;
        logic             is_assigned;
        logic [TEI_W-1:0] current_tei;
    } itm_result_t;

endpackage

`default_nettype wire

FILE: src/itm_cfg.sv
// Configuration register file: retry timeout and attempt limit.
// Depends on itm_pkg.
`default_nettype none

module itm_cfg
    import itm_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [0:0]           cfg_index,
    input  wire logic [TIMER_W-1:0]   cfg_data,
    output itm_cfg_t                  cfg_out
);

    logic [TIMER_W-1:0]   retry_reg;
    logic [ATTEMPT_W-1:0] attempts_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            retry_reg    <= RETRY_RESET;
            attempts_reg <= ATTEMPT_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_RETRY_TIMEOUT: retry_reg    <= cfg_data;
                CFG_MAX_ATTEMPTS:  attempts_reg <= cfg_data[ATTEMPT_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg_out.retry_timeout_ticks  = retry_reg;
    assign cfg_out.max_request_attempts = attempts_reg;

endmodule

`default_nettype wire

FILE: src/itm_core.sv
// Next-state and result logic for one item of the TEI manager.
// Purely combinational; depends on itm_pkg.
`default_nettype none

module itm_core
    import itm_pkg::*;
(
    input  wire itm_item_t  item,
    input  wire itm_state_t cur,
    input  wire itm_cfg_t   cfg,
    output itm_state_t  nxt,
    output itm_result_t res
);

    logic [TIMER_W-1:0] arm_value;
    logic [TIMER_W-1:0] timer_dec;
    logic               frame_ok;
    logic               target_hit;
    logic [2:0]         ev;
    logic [2:0]         smt;
    logic [REF_W-1:0]   sref;
    logic [TEI_W-1:0]   sai;

    always_comb begin
        arm_value  = (cfg.retry_timeout_ticks == '0) ? TIMER_W'(1) : cfg.retry_timeout_ticks;
        timer_dec  = (cur.timer_left != '0) ? cur.timer_left - TIMER_W'(1) : cur.timer_left;
        frame_ok   = item.frame_long_enough
                     && ((item.control_byte & CTRL_POLL_MSK) == CTRL_UI)
                     && (item.entity_id == MGMT_ENTITY);
        target_hit = cur.assigned_flag
                     && (item.frame_action_tei == TEI_BROADCAST
                         || item.frame_action_tei == cur.own_tei);

        nxt  = cur;
        ev   = EV_NONE;
        smt  = '0;
        sref = '0;
        sai  = '0;

        unique case (func_t'(item.func))
            FUNC_START: begin
                nxt.attempt_count   = ATTEMPT_W'(1);
                nxt.timer_left      = arm_value;
                nxt.timer_armed     = 1'b1;
                nxt.request_pending = 1'b1;
                nxt.assigned_flag   = 1'b0;
                nxt.own_tei         = TEI_BROADCAST;
                nxt.pending_ref     = item.random_ref;
                ev   = EV_REQUEST;
                smt  = 3'(MT_REQUEST);
                sref = item.random_ref;
                sai  = TEI_BROADCAST;
            end
            FUNC_TICK: begin
                if (cur.timer_armed) begin
                    nxt.timer_left = timer_dec;
                    if (timer_dec == '0) begin
                        if (cur.attempt_count >= cfg.max_request_attempts) begin
                            nxt.assigned_flag   = 1'b0;
                            nxt.own_tei         = TEI_BROADCAST;
                            nxt.request_pending = 1'b0;
                            nxt.pending_ref     = '0;
                            nxt.timer_armed     = 1'b0;
                            ev = EV_ERROR;
                        end else begin
                            // counter wraps in 4 bits like the attempt field
                            nxt.attempt_count = cur.attempt_count + ATTEMPT_W'(1);
                            nxt.pending_ref   = item.random_ref;
                            nxt.timer_left    = arm_value;
                            nxt.timer_armed   = 1'b1;
                            ev   = EV_REQUEST;
                            smt  = 3'(MT_REQUEST);
                            sref = item.random_ref;
                            sai  = TEI_BROADCAST;
                        end
                    end
                end
            end
            FUNC_FRAME: begin
                if (!frame_ok) begin
                    ev = EV_REJECTED;
                end else if (item.msg_code == MT_ASSIGNED) begin
                    // own identifier handed out again: duplicate, ignored
                    if (!(cur.assigned_flag && item.frame_action_tei == cur.own_tei)
                        && cur.request_pending && item.frame_ref == cur.pending_ref) begin
                        nxt.request_pending = 1'b0;
                        nxt.pending_ref     = '0;
                        nxt.own_tei         = item.frame_action_tei;
                        nxt.assigned_flag   = 1'b1;
                        nxt.timer_armed     = 1'b0;
                        nxt.timer_left      = '0;
                        ev = EV_ASSIGNED;
                    end
                end else if (item.msg_code == MT_CHECK_REQ) begin
                    if (target_hit) begin
                        ev   = EV_CHECK;
                        smt  = 3'(MT_CHECK_RSP);
                        sref = item.random_ref;
                        sai  = cur.own_tei;
                    end
                end else if (item.msg_code == MT_REMOVE) begin
                    if (target_hit) begin
                        nxt.assigned_flag = 1'b0;
                        nxt.own_tei       = TEI_BROADCAST;
                        ev = EV_REMOVED;
                    end
                end
            end
            FUNC_STATIC: begin
                nxt.own_tei       = item.static_tei;
                nxt.assigned_flag = 1'b1;
            end
            default: ;
        endcase

        res.event_res       = ev;
        res.send_msg_type   = smt;
        res.send_ref        = sref;
        res.send_action_tei = sai;
        res.is_assigned     = nxt.assigned_flag;
        res.current_tei     = nxt.assigned_flag ? nxt.own_tei : TEI_BROADCAST;
    end

endmodule

`default_nettype wire

FILE: src/isdn_user_tei_management_unit.sv
// User-side TEI manager for one ISDN link.
//
// Input channel s_*: one word per item. s_tuser carries the function
// (start request, timer tick, received frame, static identifier);
// s_tdata carries the frame fields and the fresh random reference.
// Result channel m_*: exactly one word per input word, in order.
// m_tuser is the event code, m_tdata the message to send plus the
// identifier status after the item.
// Config channel cfg_*: index 0 retry timeout in ticks, index 1 attempt limit;
// always ready; the user writes it only while the block is idle, unchecked.
// Path: a word is held in the input register, then its result is
// registered, so m_tvalid rises once the result register is loaded.
// One word per cycle is sustained while m_tready is high; the state update
// is a single pass of logic between the input and result registers.
// When m_tready is low the result register holds and one more word
// waits in the input register; s_tready then drops.
// Reset (aresetn low, synchronous) empties both registers, drops any
// identifier and stops the retry timer; config returns to 200 / 3.
// Depends on itm_pkg, itm_cfg and itm_core.
`default_nettype none

module isdn_user_tei_management_unit
    import itm_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // config write channel
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [0:0]            cfg_index,
    input  wire logic [TIMER_W-1:0]    cfg_data,
    // input stream
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // s_tdata, low bit up: random_ref[15:0], frame_long_enough[16],
    // control_byte[24:17], entity_id[32:25], msg_code[40:33],
    // frame_ref[56:41], frame_action_tei[63:57], static_tei[70:64], zero[71]
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    input  wire logic [1:0]            s_tuser,   // func
    // result stream
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // m_tdata, low bit up: send_msg_type[2:0], send_ref[18:3],
    // send_action_tei[25:19], is_assigned[26], current_tei[33:27], zero[39:34]
    output logic [M_TDATA_W-1:0]       m_tdata,
    output logic [2:0]                 m_tuser    // event_res
);

    itm_cfg_t    cfg;
    itm_item_t   item_reg;
    itm_item_t   item_next;
    logic        in_valid_reg;
    logic        out_valid_reg;
    itm_result_t res_reg;
    itm_result_t res_next;
    itm_state_t  state_reg;
    itm_state_t  state_next;
    logic        advance;
    logic        s_accept;

    itm_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_out   (cfg)
    );

    itm_core u_core (
        .item (item_reg),
        .cur  (state_reg),
        .cfg  (cfg),
        .nxt  (state_next),
        .res  (res_next)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        item_next.func              = s_tuser;
        item_next.random_ref        = s_tdata[15:0];
        item_next.frame_long_enough = s_tdata[16];
        item_next.control_byte      = s_tdata[24:17];
        item_next.entity_id         = s_tdata[32:25];
        item_next.msg_code          = s_tdata[40:33];
        item_next.frame_ref         = s_tdata[56:41];
        item_next.frame_action_tei  = s_tdata[63:57];
        item_next.static_tei        = s_tdata[70:64];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg.assigned_flag   <= 1'b0;
            state_reg.request_pending <= 1'b0;
            state_reg.pending_ref     <= '0;
            state_reg.own_tei         <= TEI_BROADCAST;
            state_reg.attempt_count   <= '0;
            state_reg.timer_left      <= '0;
            state_reg.timer_armed     <= 1'b0;
        end else begin
            if (s_accept) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            item_reg <= item_next;
        end
        if (advance) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = res_reg.event_res;
    assign m_tdata  = {6'd0, res_reg.current_tei, res_reg.is_assigned,
                       res_reg.send_action_tei, res_reg.send_ref, res_reg.send_msg_type};

endmodule

`default_nettype wire

FILE: bench/tei_result_checker.sv
`timescale 1ns / 100ps
// Result checker for the ISDN user-side TEI manager: follows config writes, predicts one
// result word per accepted input word and compares the result stream in order.
// Depends on itm_pkg.

module tei_result_checker
    import itm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [0:0]           cfg_index,
    input  logic [TIMER_W-1:0]   cfg_data,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // random_ref, long, ctrl, entity, type, ref, ai, static
    input  logic [1:0]           s_tuser,   // func
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,   // msg_type, ref, action tei, assigned, tei
    input  logic [2:0]           m_tuser,   // event_res
    output int unsigned          mismatch_cnt,
    output int unsigned          results_due
);

    itm_cfg_t    link_cfg;
    itm_state_t  link;
    itm_result_t tei_results_due[$];

    function automatic void arm_retry_timer();
        link.timer_left  = (link_cfg.retry_timeout_ticks != '0) ?
                           link_cfg.retry_timeout_ticks : TIMER_W'(1);
        link.timer_armed = 1'b1;
    endfunction

    // Advances the link state by one input word and returns the result it produces.
    function automatic itm_result_t next_tei_result(input func_t fn, input itm_item_t it);
        itm_result_t r;
        logic        targets_us;
        r = '0;
        targets_us = link.assigned_flag && (it.frame_action_tei == TEI_BROADCAST ||
                                            it.frame_action_tei == link.own_tei);
        case (fn)
            FUNC_START: begin
                link.attempt_count   = ATTEMPT_W'(1);
                arm_retry_timer();
                link.request_pending = 1'b1;
                link.assigned_flag   = 1'b0;
                link.own_tei         = TEI_BROADCAST;
                link.pending_ref     = it.random_ref;
                r.event_res          = EV_REQUEST;
                r.send_msg_type      = 3'(MT_REQUEST);
                r.send_ref           = it.random_ref;
                r.send_action_tei    = TEI_BROADCAST;
            end
            FUNC_TICK: begin
                if (link.timer_armed) begin
                    if (link.timer_left != '0)
                        link.timer_left = link.timer_left - 1'b1;
                    if (link.timer_left == '0) begin
                        if (link.attempt_count >= link_cfg.max_request_attempts) begin
                            // out of retries: back to unassigned
                            link.assigned_flag   = 1'b0;
                            link.own_tei         = TEI_BROADCAST;
                            link.request_pending = 1'b0;
                            link.pending_ref     = '0;
                            link.timer_armed     = 1'b0;
                            r.event_res          = EV_ERROR;
                        end else begin
                            link.attempt_count = link.attempt_count + 1'b1;
                            link.pending_ref   = it.random_ref;
                            arm_retry_timer();
                            r.event_res        = EV_REQUEST;
                            r.send_msg_type    = 3'(MT_REQUEST);
                            r.send_ref         = it.random_ref;
                            r.send_action_tei  = TEI_BROADCAST;
                        end
                    end
                end
            end
            FUNC_FRAME: begin
                if (!it.frame_long_enough || (it.control_byte & CTRL_POLL_MSK) != CTRL_UI ||
                    it.entity_id != MGMT_ENTITY) begin
                    r.event_res = EV_REJECTED;
                end else if (it.msg_code == MT_ASSIGNED) begin
                    // an assignment naming our own identifier is ignored
                    if (!(link.assigned_flag && it.frame_action_tei == link.own_tei) &&
                        link.request_pending && it.frame_ref == link.pending_ref) begin
                        link.request_pending = 1'b0;
                        link.pending_ref     = '0;
                        link.own_tei         = it.frame_action_tei;
                        link.assigned_flag   = 1'b1;
                        link.timer_armed     = 1'b0;
                        link.timer_left      = '0;
                        r.event_res          = EV_ASSIGNED;
                    end
                end else if (it.msg_code == MT_CHECK_REQ) begin
                    if (targets_us) begin
                        r.event_res       = EV_CHECK;
                        r.send_msg_type   = 3'(MT_CHECK_RSP);
                        r.send_ref        = it.random_ref;
                        r.send_action_tei = link.own_tei;
                    end
                end else if (it.msg_code == MT_REMOVE) begin
                    // pending request and timer keep running
                    if (targets_us) begin
                        link.assigned_flag = 1'b0;
                        link.own_tei       = TEI_BROADCAST;
                        r.event_res        = EV_REMOVED;
                    end
                end
            end
            FUNC_STATIC: begin
                link.own_tei       = it.static_tei;
                link.assigned_flag = 1'b1;
            end
        endcase
        r.is_assigned = link.assigned_flag;
        r.current_tei = link.assigned_flag ? link.own_tei : TEI_BROADCAST;
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin
        itm_result_t want;
        itm_item_t   it;
        if (!aresetn) begin
            link_cfg.retry_timeout_ticks  = RETRY_RESET;
            link_cfg.max_request_attempts = ATTEMPT_RESET;
            link                          = '0;
            link.own_tei                  = TEI_BROADCAST;
            tei_results_due.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_RETRY_TIMEOUT)
                    link_cfg.retry_timeout_ticks = cfg_data;
                else
                    link_cfg.max_request_attempts = cfg_data[ATTEMPT_W-1:0];
            end
            if (m_tvalid && m_tready) begin
                if (tei_results_due.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("%0t: result word with nothing expected, tdata %h tuser %0d",
                                 $time, m_tdata, m_tuser);
                end else begin
                    want = tei_results_due.pop_front();
                    check_field("event_res", want.event_res, m_tuser);
                    check_field("send_msg_type", want.send_msg_type, m_tdata[2:0]);
                    check_field("send_ref", want.send_ref, m_tdata[18:3]);
                    check_field("send_action_tei", want.send_action_tei, m_tdata[25:19]);
                    check_field("is_assigned", want.is_assigned, m_tdata[26]);
                    check_field("current_tei", want.current_tei, m_tdata[33:27]);
                end
            end
            if (s_tvalid && s_tready) begin
                it.func              = s_tuser;
                it.random_ref        = s_tdata[15:0];
                it.frame_long_enough = s_tdata[16];
                it.control_byte      = s_tdata[24:17];
                it.entity_id         = s_tdata[32:25];
                it.msg_code          = s_tdata[40:33];
                it.frame_ref         = s_tdata[56:41];
                it.frame_action_tei  = s_tdata[63:57];
                it.static_tei        = s_tdata[70:64];
                tei_results_due.push_back(next_tei_result(func_t'(s_tuser), it));
            end
        end
        results_due <= tei_results_due.size();
    end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// Bench top for the ISDN user-side TEI manager: clock, reset, config writes, directed and
// random input words, result backpressure and the verdict. Depends on itm_pkg, the block
// and tei_result_checker.

module tb_top;
    import itm_pkg::*;

    localparam int unsigned STALL_LIMIT     = 5000;
    localparam int unsigned WORDS_PER_PHASE = 85;

    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [0:0]           cfg_index = '0;
    logic [TIMER_W-1:0]   cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic [1:0]           s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [2:0]           m_tuser;
    int unsigned          mismatch_cnt;
    int unsigned          results_due;
    int unsigned          quiet_cycles = 0;
    bit                   no_idle      = 1'b0;
    logic [REF_W-1:0]     recent_refs[$];
    logic [TEI_W-1:0]     last_tei     = '0;

    isdn_user_tei_management_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    tei_result_checker i_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .mismatch_cnt (mismatch_cnt),
        .results_due  (results_due)
    );

    always begin
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
        #4;
    end

    always @(posedge aclk)
        m_tready <= no_idle || ($urandom_range(99) >= 11);

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic itm_item_t any_item();
        itm_item_t it;
        it.func              = '0;
        it.random_ref        = REF_W'($urandom);
        it.frame_long_enough = 1'($urandom);
        it.control_byte      = 8'($urandom);
        it.entity_id         = 8'($urandom);
        it.msg_code          = 8'($urandom);
        it.frame_ref         = REF_W'($urandom);
        it.frame_action_tei  = TEI_W'($urandom);
        it.static_tei        = TEI_W'($urandom);
        return it;
    endfunction

    // well-formed UI management frame for entity 0x0f
    function automatic itm_item_t mgmt_frame(input logic [7:0] mt, input logic [REF_W-1:0] fref,
                                             input logic [TEI_W-1:0] ai);
        itm_item_t it;
        it                   = any_item();
        it.frame_long_enough = 1'b1;
        it.control_byte      = CTRL_UI;
        it.entity_id         = MGMT_ENTITY;
        it.msg_code          = mt;
        it.frame_ref         = fref;
        it.frame_action_tei  = ai;
        return it;
    endfunction

    task automatic send_word(input func_t fn, input itm_item_t it);
        while (!no_idle && $urandom_range(99) < 11) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= fn;
        s_tdata  <= {1'b0, it.static_tei, it.frame_action_tei, it.frame_ref, it.msg_code,
                     it.entity_id, it.control_byte, it.frame_long_enough, it.random_ref};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        // any start or tick word may be the one whose ref goes out
        if (fn == FUNC_START || fn == FUNC_TICK) begin
            recent_refs.push_back(it.random_ref);
            if (recent_refs.size() > 4)
                void'(recent_refs.pop_front());
        end
        if (fn == FUNC_STATIC)
            last_tei = it.static_tei;
    endtask

    task automatic write_regs(input logic [TIMER_W-1:0] ticks, input logic [ATTEMPT_W-1:0] tries);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_RETRY_TIMEOUT;
        cfg_data  <= ticks;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cfg_index <= CFG_MAX_ATTEMPTS;
        cfg_data  <= {12'($urandom), tries};   // upper bits are don't-care
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do
            @(posedge aclk);
        while (results_due != 0);
        repeat (3) @(posedge aclk);
    endtask

    task automatic rand_item(output func_t fn, output itm_item_t it);
        int unsigned      pick;
        logic [7:0]       mt;
        logic [REF_W-1:0] fref;
        logic [TEI_W-1:0] ai;
        it   = any_item();
        pick = $urandom_range(99);
        if (pick < 8)
            fn = FUNC_START;
        else if (pick < 46)
            fn = FUNC_TICK;
        else if (pick < 95)
            fn = FUNC_FRAME;
        else
            fn = FUNC_STATIC;
        // random header on a few frames: mostly rejected
        if (fn != FUNC_FRAME || $urandom_range(99) < 12)
            return;
        pick = $urandom_range(99);
        if (pick < 40)
            mt = MT_ASSIGNED;
        else if (pick < 65)
            mt = MT_CHECK_REQ;
        else if (pick < 85)
            mt = MT_REMOVE;
        else if (pick < 90)
            mt = MT_DENIED;
        else if (pick < 93)
            mt = MT_REQUEST;
        else if (pick < 96)
            mt = MT_CHECK_RSP;
        else
            mt = 8'($urandom);
        if (recent_refs.size() != 0 && $urandom_range(3) != 0)
            fref = recent_refs[$urandom_range(recent_refs.size() - 1)];
        else
            fref = REF_W'($urandom);
        pick = $urandom_range(99);
        if (pick < 25) begin
            ai = TEI_BROADCAST;
        end else if (pick < 60) begin
            ai = last_tei;
        end else begin
            ai = TEI_W'($urandom_range(126));
            if (mt == MT_ASSIGNED)
                last_tei = ai;
        end
        it = mgmt_frame(mt, fref, ai);
        if ($urandom_range(1))
            it.control_byte = CTRL_UI | 8'h10;
        if ($urandom_range(19) == 0)
            it.frame_long_enough = 1'b0;
    endtask

    task automatic run_phase(input logic [TIMER_W-1:0] ticks, input logic [ATTEMPT_W-1:0] tries,
                             input bit calm);
        func_t     fn;
        itm_item_t it;
        wait_drained();
        write_regs(ticks, tries);
        no_idle <= calm;
        repeat (WORDS_PER_PHASE) begin
            rand_item(fn, it);
            send_word(fn, it);
        end
    endtask

    initial begin
        itm_item_t w;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        write_regs(16'd3, 4'd2);

        // idle link: tick and check do nothing
        send_word(FUNC_TICK, any_item());
        send_word(FUNC_FRAME, mgmt_frame(MT_CHECK_REQ, 16'h0000, TEI_BROADCAST));
        w = any_item();
        w.static_tei = '0;
        send_word(FUNC_STATIC, w);
        send_word(FUNC_FRAME, mgmt_frame(MT_CHECK_REQ, 16'hffff, TEI_BROADCAST));
        send_word(FUNC_FRAME, mgmt_frame(MT_CHECK_REQ, 16'h5a5a, 7'd0));
        send_word(FUNC_FRAME, mgmt_frame(MT_CHECK_REQ, 16'h5a5a, 7'h12));
        send_word(FUNC_FRAME, mgmt_frame(MT_REMOVE, 16'h0000, 7'h12));
        send_word(FUNC_FRAME, mgmt_frame(MT_REMOVE, 16'h0000, 7'd0));
        w = any_item();
        w.random_ref = 16'hffff;
        send_word(FUNC_START, w);
        // rejects: short, wrong control, wrong entity; poll bit alone is fine
        w = mgmt_frame(MT_ASSIGNED, 16'hffff, 7'h40);
        w.frame_long_enough = 1'b0;
        send_word(FUNC_FRAME, w);
        w = mgmt_frame(MT_ASSIGNED, 16'h1234, 7'h40);
        w.control_byte = CTRL_UI | 8'h10;
        send_word(FUNC_FRAME, w);
        w = mgmt_frame(MT_ASSIGNED, 16'hffff, 7'h40);
        w.control_byte = 8'hff;
        send_word(FUNC_FRAME, w);
        w = mgmt_frame(MT_ASSIGNED, 16'hffff, 7'h40);
        w.entity_id = 8'hf0;
        send_word(FUNC_FRAME, w);
        w = mgmt_frame(MT_ASSIGNED, 16'hffff, TEI_BROADCAST);
        w.control_byte = CTRL_UI | 8'h10;
        send_word(FUNC_FRAME, w);
        send_word(FUNC_FRAME, mgmt_frame(MT_ASSIGNED, 16'hffff, TEI_BROADCAST));
        send_word(FUNC_FRAME, mgmt_frame(MT_DENIED, 16'hffff, TEI_BROADCAST));
        send_word(FUNC_FRAME, mgmt_frame(8'hff, 16'hffff, TEI_BROADCAST));
        send_word(FUNC_FRAME, mgmt_frame(MT_REQUEST, 16'hffff, TEI_BROADCAST));
        send_word(FUNC_FRAME, mgmt_frame(MT_CHECK_RSP, 16'hffff, TEI_BROADCAST));
        // restart while assigned, then one retry and give-up
        w = any_item();
        w.random_ref = 16'h0000;
        send_word(FUNC_START, w);
        repeat (6) send_word(FUNC_TICK, any_item());
        w = any_item();
        w.static_tei = TEI_BROADCAST;
        send_word(FUNC_STATIC, w);

        run_phase(RETRY_RESET, ATTEMPT_RESET, 1'b0);
        run_phase(16'd0, 4'd0, 1'b0);
        run_phase(16'd1, 4'd1, 1'b1);
        run_phase(16'hffff, 4'd15, 1'b0);
        run_phase(16'd4, 4'd15, 1'b0);
        run_phase(16'd2, 4'd2, 1'b0);
        wait_drained();
        repeat (8) @(posedge aclk);

        if (mismatch_cnt == 0 && results_due == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
